// ----- sv/point_in_polygon_ray_cast_top_assert.svh -----
// assertion macros for the point in polygon block
// expects clk and rst in the scope where a macro is used
`ifndef POINT_IN_POLYGON_RAY_CAST_TOP_ASSERT_SVH
`define POINT_IN_POLYGON_RAY_CAST_TOP_ASSERT_SVH

// same-cycle implication
`define PIP_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PIP_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/pip_pkg.sv -----
// shared constants and types for the point in polygon block
// no dependencies
`timescale 1ns / 1ps

package pip_pkg;

  localparam int MAX_VERTICES_DEF  = 256;
  localparam int COORD_WIDTH_DEF   = 24;
  localparam int MIN_POLY_VERTICES = 3;
  localparam int RAY_FAR_RESET     = 10000;

  // fixed field widths of the word and register layout
  localparam int SLOT_W   = 8;
  localparam int VCOUNT_W = 9;

  // item kinds carried in tuser
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // configuration register indexes
  localparam logic CFG_VERTEX_COUNT = 1'b0;
  localparam logic CFG_RAY_FAR_X    = 1'b1;

  typedef enum logic [1:0] {
    ORI_COL = 2'd0,
    ORI_CW  = 2'd1,
    ORI_CCW = 2'd2
  } orient_t;

endpackage

// ----- sv/point_in_polygon_ray_cast_top.sv -----
// point in polygon test by ray casting, vertex table and edge walker
// channels: s_* input words, m_* result words, cfg_* register writes.
// a word with tuser = 0 stores one vertex at vertex_index and gives no result;
// it is taken without leaving the idle state and the input stays ready.
// a word with tuser = 1 queries a point and gives one result word.
// with fewer than three vertices in use the walk is skipped and the answer is outside.
// otherwise the edges are walked one after another through a single shared
// multiplier: three products and a decision per edge (steps M0 to M3, DEC);
// a collinear hit ends the walk early. s_tready is low during the walk.
// the result sits in an output register; while the receiver stalls, a new
// query may finish its walk but waits there until the register frees up.
// configuration is taken at any time and is meant to be written while idle.
// reset (rst, synchronous) empties the output, sets vertex_count to 0 and
// ray_far_x to 10000; the vertex table is not cleared.
// depends on pip_pkg and point_in_polygon_ray_cast_top_assert.svh
`timescale 1ns / 1ps
`include "point_in_polygon_ray_cast_top_assert.svh"

module point_in_polygon_ray_cast_top
  import pip_pkg::*;
#(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF,
  parameter int COORD_WIDTH  = COORD_WIDTH_DEF,
  localparam int IDX_W = $clog2(MAX_VERTICES),
  localparam int CNT_W = ($clog2(MAX_VERTICES + 1) > VCOUNT_W) ? $clog2(MAX_VERTICES + 1)
                                                                : VCOUNT_W,
  localparam int SD_W  = ((SLOT_W + 2 * COORD_WIDTH + 7) / 8) * 8,
  localparam int MD_W  = 8,
  localparam int CFG_W = (COORD_WIDTH > VCOUNT_W) ? COORD_WIDTH : VCOUNT_W
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [SD_W-1:0]  s_tdata,   // vertex_index, point_x, point_y
  input  logic             s_tuser,   // operation
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [MD_W-1:0]  m_tdata,   // inside_res
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  localparam int CW = COORD_WIDTH;
  localparam int DW = CW + 1;
  localparam int PW = 2 * DW;

  typedef enum logic [3:0] {
    S_IDLE, S_RD0, S_LD0, S_LDB, S_M0, S_M1, S_M2, S_M3, S_DEC, S_EMIT
  } state_t;

  state_t state;

  logic                 in_acc;
  logic                 cfg_we;
  logic [SLOT_W-1:0]    in_slot;
  logic [IDX_W-1:0]     in_idx;
  logic [CW-1:0]        in_x;
  logic [CW-1:0]        in_y;
  logic                 wr_ok;

  logic [VCOUNT_W-1:0]  vertex_count;
  logic signed [CW-1:0] ray_far_x;
  logic [CNT_W-1:0]     cnt_sat;

  logic [2*CW-1:0]      vmem [MAX_VERTICES];
  logic [2*CW-1:0]      rd_q;
  logic signed [CW-1:0] rd_x;
  logic signed [CW-1:0] rd_y;
  logic [IDX_W-1:0]     addr;

  logic signed [CW-1:0] px, py, ax, ay, bx, by, v0x, v0y;
  logic [CNT_W-1:0]     n_q;
  logic [CNT_W-1:0]     idx;
  logic [CNT_W-1:0]     idx_next;
  logic [CNT_W-1:0]     idx_next2;

  logic [DW-1:0]        dy_ba, dx_ba, dx_pb, dy_pb, dx_fb;
  logic signed [DW-1:0] mul_a;
  logic signed [DW-1:0] mul_b;
  logic signed [PW-1:0] mul_p;
  logic signed [PW-1:0] prod_q;
  logic signed [PW-1:0] hold_q;
  logic [PW:0]          sub_a;
  logic [PW:0]          sub_b;
  logic [PW:0]          dif;

  orient_t              o1, o2, o3, o4;
  logic                 far_gt, far_lt;
  logic                 box_apb, box_afb, box_paf, box_pbf;
  logic                 meet;
  logic                 odd;
  logic                 odd_next;
  logic                 hit_edge;
  logic                 dec_done;
  logic                 dec_result;
  logic                 result_q;
  logic                 inside_q;

  function automatic orient_t orient_of(logic [PW:0] d);
    return (d == '0) ? ORI_COL : (d[PW] ? ORI_CCW : ORI_CW);
  endfunction

  // orientation of (p, far, a) where far shares the y of p
  function automatic orient_t flat_orient(logic gt, logic lt,
                                          logic signed [CW-1:0] y,
                                          logic signed [CW-1:0] yref);
    return ((gt && y < yref) || (lt && y > yref)) ? ORI_CW :
           (((gt && y > yref) || (lt && y < yref)) ? ORI_CCW : ORI_COL);
  endfunction

  function automatic logic in_range(logic signed [CW-1:0] v,
                                    logic signed [CW-1:0] a,
                                    logic signed [CW-1:0] c);
    return (v <= a || v <= c) && (v >= a || v >= c);
  endfunction

  assign s_tready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_acc    = s_tvalid && s_tready;
  assign cfg_we    = cfg_valid && cfg_ready;
  assign m_tdata   = MD_W'(inside_q);

  assign in_slot = s_tdata[SLOT_W-1:0];
  assign in_idx  = IDX_W'(in_slot);
  assign in_x    = s_tdata[SLOT_W +: CW];
  assign in_y    = s_tdata[SLOT_W + CW +: CW];
  assign wr_ok   = (CNT_W'(in_slot) < CNT_W'(MAX_VERTICES));

  assign cnt_sat = (CNT_W'(vertex_count) > CNT_W'(MAX_VERTICES)) ? CNT_W'(MAX_VERTICES)
                                                                 : CNT_W'(vertex_count);

  assign rd_x = rd_q[CW-1:0];
  assign rd_y = rd_q[2*CW-1:CW];

  assign idx_next  = idx + CNT_W'(1);
  assign idx_next2 = idx + CNT_W'(2);

  // operand differences, sign extended by one bit
  assign dy_ba = {by[CW-1], by} - {ay[CW-1], ay};
  assign dx_ba = {bx[CW-1], bx} - {ax[CW-1], ax};
  assign dx_pb = {px[CW-1], px} - {bx[CW-1], bx};
  assign dy_pb = {py[CW-1], py} - {by[CW-1], by};
  assign dx_fb = {ray_far_x[CW-1], ray_far_x} - {bx[CW-1], bx};

  // shared multiplier: (by-ay)(px-bx), (bx-ax)(py-by), (by-ay)(fx-bx)
  assign mul_a = (state == S_M1) ? dx_ba : dy_ba;
  assign mul_b = (state == S_M0) ? dx_pb : ((state == S_M1) ? dy_pb : dx_fb);
  assign mul_p = mul_a * mul_b;

  assign sub_a = (state == S_M2) ? {hold_q[PW-1], hold_q} : {prod_q[PW-1], prod_q};
  assign sub_b = (state == S_M2) ? {prod_q[PW-1], prod_q} : {hold_q[PW-1], hold_q};
  assign dif   = sub_a - sub_b;

  assign far_gt = (ray_far_x > px);
  assign far_lt = (ray_far_x < px);
  assign o3     = flat_orient(far_gt, far_lt, ay, py);
  assign o4     = flat_orient(far_gt, far_lt, by, py);

  assign box_apb = in_range(px, ax, bx) && in_range(py, ay, by);
  assign box_afb = in_range(ray_far_x, ax, bx) && in_range(py, ay, by);
  assign box_paf = in_range(ax, px, ray_far_x) && (ay == py);
  assign box_pbf = in_range(bx, px, ray_far_x) && (by == py);

  assign meet = ((o1 != o2) && (o3 != o4)) ||
                (o1 == ORI_COL && box_apb) || (o2 == ORI_COL && box_afb) ||
                (o3 == ORI_COL && box_paf) || (o4 == ORI_COL && box_pbf);

  assign hit_edge   = meet && (o1 == ORI_COL);
  assign odd_next   = odd ^ meet;
  assign dec_done   = hit_edge || (idx_next == n_q);
  assign dec_result = hit_edge ? box_apb : odd_next;

  // vertex table, x in the low half
  always_ff @(posedge clk) begin
    if (in_acc && s_tuser == OP_WRITE && wr_ok) begin
      vmem[in_idx] <= {in_y, in_x};
    end
    rd_q <= vmem[addr];
  end

  always_ff @(posedge clk) begin
    prod_q <= mul_p;
    hold_q <= prod_q;
    if (in_acc) begin
      px       <= in_x;
      py       <= in_y;
      n_q      <= cnt_sat;
      addr     <= '0;
      idx      <= '0;
      odd      <= 1'b0;
      result_q <= 1'b0;
    end
    if (state == S_RD0) begin
      addr <= addr + IDX_W'(1);
    end
    if (state == S_LD0) begin
      ax   <= rd_x;
      ay   <= rd_y;
      v0x  <= rd_x;
      v0y  <= rd_y;
      addr <= addr + IDX_W'(1);
    end
    if (state == S_LDB) begin
      bx <= rd_x;
      by <= rd_y;
    end
    if (state == S_M2) begin
      o1 <= orient_of(dif);
    end
    if (state == S_M3) begin
      o2 <= orient_of(dif);
    end
    if (state == S_DEC) begin
      odd      <= odd_next;
      idx      <= idx_next;
      addr     <= addr + IDX_W'(1);
      ax       <= bx;
      ay       <= by;
      bx       <= (idx_next2 == n_q) ? v0x : rd_x;
      by       <= (idx_next2 == n_q) ? v0y : rd_y;
      result_q <= dec_result;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      m_tvalid     <= 1'b0;
      vertex_count <= '0;
      ray_far_x    <= CW'(RAY_FAR_RESET);
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_VERTEX_COUNT: vertex_count <= cfg_data[VCOUNT_W-1:0];
          CFG_RAY_FAR_X:    ray_far_x    <= cfg_data[CW-1:0];
        endcase
      end
      if (m_tvalid && m_tready && state != S_EMIT) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_acc && s_tuser == OP_QUERY) begin
            state <= (cnt_sat < CNT_W'(MIN_POLY_VERTICES)) ? S_EMIT : S_RD0;
          end
        end
        S_RD0: state <= S_LD0;
        S_LD0: state <= S_LDB;
        S_LDB: state <= S_M0;
        S_M0:  state <= S_M1;
        S_M1:  state <= S_M2;
        S_M2:  state <= S_M3;
        S_M3:  state <= S_DEC;
        S_DEC: state <= dec_done ? S_EMIT : S_M0;
        S_EMIT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            inside_q <= result_q;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `PIP_ASSERT_NEXT(a_query_start, in_acc && s_tuser == OP_QUERY && cnt_sat >= CNT_W'(MIN_POLY_VERTICES), state == S_RD0, "query with a polygon did not start the edge walk")
  `PIP_ASSERT_NEXT(a_short_poly, in_acc && s_tuser == OP_QUERY && cnt_sat < CNT_W'(MIN_POLY_VERTICES), state == S_EMIT && result_q == 1'b0, "short polygon query not answered outside")
  `PIP_ASSERT_NOW(a_edge_range, state == S_DEC, idx < n_q && n_q >= CNT_W'(MIN_POLY_VERTICES), "edge index beyond vertex count")
  `PIP_ASSERT_NOW(a_result_src, $rose(m_tvalid), $past(state) == S_EMIT, "result word raised outside the emit step")
  `PIP_ASSERT_NEXT(a_write_stays, in_acc && s_tuser == OP_WRITE, state == S_IDLE, "vertex write left the idle state")

endmodule
